[src/scbp_pkg.sv]
package scbp_pkg;

  // Default number of scene table entries.
  localparam int unsigned SceneCountDefault = 16;

  // Reset value of the long-press threshold register.
  localparam logic [7:0] LongPressReset = 8'd50;

  // Event kinds as they arrive on the input channel.
  typedef enum logic [1:0] {
    EVT_PRESS   = 2'd0,
    EVT_RELEASE = 2'd1,
    EVT_TICK    = 2'd2,
    EVT_RECALL  = 2'd3
  } evt_e;

  // Commands sent to the dim engine.
  typedef enum logic [2:0] {
    DIM_NONE        = 3'd0,
    DIM_TARGET_UP   = 3'd1,
    DIM_TARGET_IDLE = 3'd2,
    DIM_PREPARE     = 3'd3,
    DIM_STOP_NOW    = 3'd4,
    DIM_STOP_END    = 3'd5,
    DIM_TO_ZERO     = 3'd6
  } dim_cmd_e;

  // Operations after classification by the front end.
  typedef enum logic [2:0] {
    OP_IGNORE         = 3'd0,
    OP_PRESS_TOGGLE   = 3'd1,
    OP_RELEASE_TOGGLE = 3'd2,
    OP_TICK           = 3'd3,
    OP_SELECT         = 3'd4
  } op_e;

  // One queued operation.
  typedef struct packed {
    op_e        op;
    logic [3:0] scene;
  } entry_t;

  // One scene table record.
  typedef struct packed {
    logic       on;
    logic       armed;
    logic [7:0] hold;
  } scene_rec_t;

endpackage

[src/scbp_front.sv]
module scbp_front #(
  parameter int unsigned SceneCount = scbp_pkg::SceneCountDefault
) (
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       cmd_i,
  input  logic [3:0]       scene_index_i,
  input  logic             active_mode_i,
  input  logic             queue_full_i,
  output logic             push_o,
  output scbp_pkg::entry_t entry_o
);
  import scbp_pkg::*;

  // Wide enough to hold both the scene index and the scene count.
  localparam int unsigned CntW = $clog2(SceneCount + 1);
  localparam int unsigned IdxW = (CntW > 4) ? CntW : 4;

  logic in_range;
  evt_e evt;

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  assign in_range = IdxW'(scene_index_i) < IdxW'(SceneCount);
  assign evt      = evt_e'(cmd_i);

  always_comb begin
    entry_o.scene = scene_index_i;
    entry_o.op    = OP_IGNORE;
    if (in_range) begin
      case (evt)
        EVT_PRESS: begin
          entry_o.op = active_mode_i ? OP_PRESS_TOGGLE : OP_SELECT;
        end
        EVT_RELEASE: begin
          // A release in plain mode changes nothing and emits no command.
          entry_o.op = active_mode_i ? OP_RELEASE_TOGGLE : OP_IGNORE;
        end
        EVT_TICK: begin
          entry_o.op = OP_TICK;
        end
        EVT_RECALL: begin
          entry_o.op = OP_SELECT;
        end
        default: begin
          entry_o.op = OP_IGNORE;
        end
      endcase
    end
  end

endmodule

[src/scbp_queue.sv]
module scbp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  scbp_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output scbp_pkg::entry_t entry_o
);
  import scbp_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  entry_t            slot_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o  = count_q == CntW'(Depth);
  assign empty_o = count_q == '0;
  assign entry_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Depth))
    else $error("queue count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("queue popped while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue count did not follow a push");
`endif

endmodule

[src/scbp_back.sv]
module scbp_back #(
  parameter int unsigned SceneCount = scbp_pkg::SceneCountDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       long_press_ticks_i,
  input  logic             empty_i,
  input  scbp_pkg::entry_t entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [2:0]       dim_command_o,
  output logic [3:0]       dim_scene_o,
  output logic [3:0]       selected_scene_o
);
  import scbp_pkg::*;

  localparam int unsigned AddrW = (SceneCount > 1) ? $clog2(SceneCount) : 1;
  localparam int unsigned IdxW  = (AddrW > 4) ? AddrW : 4;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e           state_q, state_d;
  entry_t           entry_q;
  scene_rec_t       table_mem [SceneCount];
  logic [SceneCount-1:0] vld_q;
  scene_rec_t       rd_rec_q;
  logic             rd_vld_q;
  logic [IdxW-1:0]  rd_idx, wr_idx;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic             exec;
  scene_rec_t       rec, new_rec;
  logic             is_long;
  logic             wr_en;
  dim_cmd_e         dc;
  logic [3:0]       last_scene_q, last_scene_d;
  logic             out_valid_q, out_valid_d;
  dim_cmd_e         dim_cmd_q;
  logic [3:0]       dim_scene_q;
  logic [3:0]       sel_scene_q;

  assign rd_idx  = IdxW'(entry_i.scene);
  assign wr_idx  = IdxW'(entry_q.scene);
  assign rd_addr = rd_idx[AddrW-1:0];
  assign wr_addr = wr_idx[AddrW-1:0];

  assign exec  = state_q == ST_EXEC;
  // The output register is empty in the execute cycle when it is free, or freeing, now.
  assign pop_o = (state_q == ST_IDLE) && !empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Entries never written read as the cleared record.
  assign rec     = rd_vld_q ? rd_rec_q : '0;
  assign is_long = rec.hold >= long_press_ticks_i;

  always_comb begin
    new_rec      = rec;
    dc           = DIM_NONE;
    wr_en        = 1'b0;
    last_scene_d = last_scene_q;
    case (entry_q.op)
      OP_PRESS_TOGGLE: begin
        last_scene_d = entry_q.scene;
        wr_en        = 1'b1;
        new_rec.hold = '0;
        if (!rec.on) begin
          new_rec.on    = 1'b1;
          new_rec.armed = 1'b0;
          dc            = DIM_TARGET_UP;
        end else begin
          new_rec.armed = 1'b1;
          dc            = DIM_PREPARE;
        end
      end
      OP_RELEASE_TOGGLE: begin
        wr_en = 1'b1;
        if (rec.armed) begin
          if (is_long) begin
            dc = DIM_STOP_NOW;
          end else begin
            new_rec.on = 1'b0;
            dc         = DIM_TO_ZERO;
          end
          new_rec.armed = 1'b0;
        end else begin
          dc = is_long ? DIM_STOP_NOW : DIM_STOP_END;
        end
      end
      OP_TICK: begin
        wr_en = 1'b1;
        if (rec.hold < long_press_ticks_i) begin
          new_rec.hold = rec.hold + 8'd1;
        end
      end
      OP_SELECT: begin
        last_scene_d = entry_q.scene;
        dc           = DIM_TARGET_IDLE;
      end
      default: begin
        dc = DIM_NONE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      last_scene_q <= '0;
      vld_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (exec) begin
        last_scene_q <= last_scene_d;
        if (wr_en) begin
          vld_q[wr_addr] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec && wr_en) begin
      table_mem[wr_addr] <= new_rec;
    end
    if (pop_o) begin
      rd_rec_q <= table_mem[rd_addr];
      rd_vld_q <= vld_q[rd_addr];
      entry_q  <= entry_i;
    end
    if (exec) begin
      dim_cmd_q   <= dc;
      dim_scene_q <= entry_q.scene;
      sel_scene_q <= last_scene_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign dim_command_o    = 3'(dim_cmd_q);
  assign dim_scene_o      = dim_scene_q;
  assign selected_scene_o = sel_scene_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) exec |=> state_q == ST_IDLE)
    else $error("execute cycle not followed by idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni) exec |-> !out_valid_q)
    else $error("result overwrites a word not yet taken");
  assert property (@(posedge clk_i) disable iff (!rst_ni) exec |-> $past(pop_o))
    else $error("execute cycle without a preceding pop");
`endif

endmodule

[src/scene_button_press_controller_unit.sv]
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    cmd_i, scene_index_i, active_mode_i
// out      output     out_valid_o / out_ready_i  dim_command_o, dim_scene_o, selected_scene_o
// cfg      input      cfg_we_i (no wait)         cfg_wdata_i (long-press threshold)
//
// In the back end each word first has its scene record read from the table memory
// into its read register; then the record is updated and written back, and the
// result register is loaded. The back end pops no new word while it executes one.
// A two-word queue lets the front end keep accepting while the back end or the
// output side stalls. Reset clears the per-entry valid bits at once, so the tables
// read as zero right after reset with no clearing pass.
module scene_button_press_controller_unit #(
  parameter int unsigned SceneCount = scbp_pkg::SceneCountDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic [3:0] scene_index_i,
  input  logic       active_mode_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] dim_command_o,
  output logic [3:0] dim_scene_o,
  output logic [3:0] selected_scene_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);
  import scbp_pkg::*;

  // Long-press threshold. The user must write it only while the block is idle; the
  // block itself does not enforce this. So the back end may read it directly.
  logic [7:0] long_press_ticks_q;

  logic   push;
  logic   pop;
  logic   queue_full;
  logic   queue_empty;
  entry_t front_entry;
  entry_t head_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_ticks_q <= LongPressReset;
    end else if (cfg_we_i) begin
      long_press_ticks_q <= cfg_wdata_i;
    end
  end

  // The front end checks the scene range and folds the event kind and mode into one
  // operation, so the back end never looks at the raw command.
  scbp_front #(
    .SceneCount (SceneCount)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .scene_index_i (scene_index_i),
    .active_mode_i (active_mode_i),
    .queue_full_i  (queue_full),
    .push_o        (push),
    .entry_o       (front_entry)
  );

  scbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (queue_full),
    .pop_i   (pop),
    .empty_o (queue_empty),
    .entry_o (head_entry)
  );

  // The back end owns the scene tables and the last selected scene, and produces
  // exactly one result word for every operation it pops.
  scbp_back #(
    .SceneCount (SceneCount)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .long_press_ticks_i (long_press_ticks_q),
    .empty_i            (queue_empty),
    .entry_i            (head_entry),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .dim_command_o      (dim_command_o),
    .dim_scene_o        (dim_scene_o),
    .selected_scene_o   (selected_scene_o)
  );

endmodule
